// File: rtl/mgac_pkg.sv
package mgac_pkg;

    localparam int unsigned GREEN_W = 8;
    localparam int unsigned OCC_W   = 11;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned EXC_W   = 9;
    localparam int unsigned CFG_W   = 11;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    // regular release chains into overwrite once this many exceedances are seen
    localparam logic [EXC_W-1:0] EXCEED_TO_OVERWRITE = EXC_W'(2);
    localparam logic [EXC_W-1:0] EXCEED_MAX          = '1;
    localparam logic [CNT_W-1:0] ADJUST_MAX          = '1;

    typedef enum logic [2:0] {
        CFG_GREEN_UPPER   = 3'd0,
        CFG_GREEN_LOWER   = 3'd1,
        CFG_GREEN_STEP    = 3'd2,
        CFG_LEFT_THRESH   = 3'd3,
        CFG_RIGHT_THRESH  = 3'd4,
        CFG_CYC_TO_REL    = 3'd5,
        CFG_REGULAR_CYC   = 3'd6,
        CFG_OVERWRITE_CYC = 3'd7
    } t_cfg_idx;

    localparam logic [GREEN_W-1:0] RST_GREEN_UPPER   = 8'd60;
    localparam logic [GREEN_W-1:0] RST_GREEN_LOWER   = 8'd20;
    localparam logic [GREEN_W-1:0] RST_GREEN_STEP    = 8'd5;
    localparam logic [OCC_W-1:0]   RST_LEFT_THRESH   = 11'd307;
    localparam logic [OCC_W-1:0]   RST_RIGHT_THRESH  = 11'd307;
    localparam logic [CNT_W-1:0]   RST_CYC_TO_REL    = 8'd10;
    localparam logic [CNT_W-1:0]   RST_REGULAR_CYC   = 8'd2;
    localparam logic [CNT_W-1:0]   RST_OVERWRITE_CYC = 8'd2;

endpackage

// File: rtl/max_green_adjust_controller.sv
// Maximum-green adjustment controller: one transaction per signal cycle carries the activation
// flag and the left- and right-turn occupancies (1024 = 1.0); one result transaction comes back
// with the new maximum green and the two release-mode flags. The block takes a new transaction
// every clock while results are being taken. A result passes through the input register, then
// the result register, which loads only when empty or when its result is being taken. While a
// result waits to be taken the input register can still take one more transaction, after which
// the input side stalls until the result is taken. Configuration registers are written through
// the plain write port while the block is idle; the user must ensure this, the block does not.
module max_green_adjust_controller
    import mgac_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] activated, [11:1] left_occ, [22:12] right_occ, [23] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] max_green, [8] in_regular_release, [9] in_overwrite_release, [15:10] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // configuration
    logic [GREEN_W-1:0] r_upper, r_lower, r_step;
    logic [OCC_W-1:0]   r_left_thr, r_right_thr;
    logic [CNT_W-1:0]   r_cyc_to_rel, r_reg_cyc, r_ow_cyc;

    // controller state
    logic [GREEN_W-1:0] r_last_green, n_last_green;
    logic               r_reg_mode, n_reg_mode;
    logic               r_ow_mode, n_ow_mode;
    logic [CNT_W-1:0]   r_reg_left, n_reg_left;
    logic [CNT_W-1:0]   r_ow_left, n_ow_left;
    logic [CNT_W-1:0]   r_cyc_adj, n_cyc_adj;
    logic [EXC_W-1:0]   r_exceed, n_exceed;

    // pipeline
    logic               r_in_valid;
    logic               r_in_act;
    logic [OCC_W-1:0]   r_in_left, r_in_right;
    logic               r_out_valid;
    logic [GREEN_W-1:0] r_out_green, n_green;
    logic               r_out_reg, r_out_ow;

    logic               advance;
    logic [EXC_W-1:0]   exceed_inc;
    logic [CNT_W-1:0]   cyc_inc;
    logic [GREEN_W:0]   green_sum;
    logic [GREEN_W-1:0] green_diff;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_ow, r_out_reg, r_out_green};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper      <= RST_GREEN_UPPER;
            r_lower      <= RST_GREEN_LOWER;
            r_step       <= RST_GREEN_STEP;
            r_left_thr   <= RST_LEFT_THRESH;
            r_right_thr  <= RST_RIGHT_THRESH;
            r_cyc_to_rel <= RST_CYC_TO_REL;
            r_reg_cyc    <= RST_REGULAR_CYC;
            r_ow_cyc     <= RST_OVERWRITE_CYC;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GREEN_UPPER:   r_upper      <= i_cfg_data[GREEN_W-1:0];
                CFG_GREEN_LOWER:   r_lower      <= i_cfg_data[GREEN_W-1:0];
                CFG_GREEN_STEP:    r_step       <= i_cfg_data[GREEN_W-1:0];
                CFG_LEFT_THRESH:   r_left_thr   <= i_cfg_data[OCC_W-1:0];
                CFG_RIGHT_THRESH:  r_right_thr  <= i_cfg_data[OCC_W-1:0];
                CFG_CYC_TO_REL:    r_cyc_to_rel <= i_cfg_data[CNT_W-1:0];
                CFG_REGULAR_CYC:   r_reg_cyc    <= i_cfg_data[CNT_W-1:0];
                CFG_OVERWRITE_CYC: r_ow_cyc     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        exceed_inc = (r_in_right > r_right_thr && r_exceed != EXCEED_MAX)
                   ? r_exceed + EXC_W'(1) : r_exceed;
        cyc_inc    = (r_cyc_adj != ADJUST_MAX) ? r_cyc_adj + CNT_W'(1) : r_cyc_adj;
        green_sum  = {1'b0, r_last_green} + {1'b0, r_step};
        green_diff = r_last_green - r_step;

        n_green      = r_upper;
        n_last_green = r_last_green;
        n_reg_mode   = r_reg_mode;
        n_ow_mode    = r_ow_mode;
        n_reg_left   = r_reg_left;
        n_ow_left    = r_ow_left;
        n_cyc_adj    = r_cyc_adj;
        n_exceed     = r_exceed;

        priority if (!r_in_act) begin
            n_last_green = r_upper;
            n_reg_mode   = 1'b0;
            n_ow_mode    = 1'b0;
            n_reg_left   = '0;
            n_ow_left    = '0;
            n_cyc_adj    = '0;
        end else if (r_ow_mode) begin
            if (r_ow_left <= CNT_W'(1)) begin
                n_ow_left = '0;
                n_ow_mode = 1'b0;
            end else begin
                n_ow_left = r_ow_left - CNT_W'(1);
            end
        end else if (r_reg_mode) begin
            if (r_reg_left <= CNT_W'(1)) begin
                n_reg_left = '0;
                n_reg_mode = 1'b0;
                n_cyc_adj  = '0;
                if (exceed_inc >= EXCEED_TO_OVERWRITE) begin
                    n_ow_mode = 1'b1;
                    n_ow_left = r_ow_cyc;
                end
                n_exceed = '0;
            end else begin
                n_reg_left = r_reg_left - CNT_W'(1);
                n_exceed   = exceed_inc;
            end
        end else begin
            if (r_in_left > r_left_thr) begin
                // stepping below zero lands on the lower bound
                if (r_last_green < r_step || green_diff < r_lower) begin
                    n_green = r_lower;
                end else begin
                    n_green = green_diff;
                end
            end else begin
                if (green_sum > {1'b0, r_upper}) begin
                    n_green = r_upper;
                end else begin
                    n_green = green_sum[GREEN_W-1:0];
                end
            end
            n_exceed  = exceed_inc;
            n_cyc_adj = cyc_inc;
            if (cyc_inc == r_cyc_to_rel) begin
                n_reg_mode = 1'b1;
                n_reg_left = r_reg_cyc;
            end
            n_last_green = n_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_green <= RST_GREEN_UPPER;
            r_reg_mode   <= 1'b0;
            r_ow_mode    <= 1'b0;
            r_reg_left   <= '0;
            r_ow_left    <= '0;
            r_cyc_adj    <= '0;
            r_exceed     <= '0;
        end else if (advance) begin
            r_last_green <= n_last_green;
            r_reg_mode   <= n_reg_mode;
            r_ow_mode    <= n_ow_mode;
            r_reg_left   <= n_reg_left;
            r_ow_left    <= n_ow_left;
            r_cyc_adj    <= n_cyc_adj;
            r_exceed     <= n_exceed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_act   <= s_axis_tdata[0];
            r_in_left  <= s_axis_tdata[OCC_W:1];
            r_in_right <= s_axis_tdata[2*OCC_W:OCC_W+1];
        end
        if (advance) begin
            r_out_green <= n_green;
            r_out_reg   <= n_reg_mode;
            r_out_ow    <= n_ow_mode;
        end
    end

endmodule

// File: rtl/mgac_checker.sv
module mgac_checker
    import mgac_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // regular and overwrite release never run together
    a_modes_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("both release modes reported");

    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // no result directly out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind max_green_adjust_controller mgac_checker u_mgac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/max_green_adjust_controller_tb.sv
`timescale 1ns / 100ps

module max_green_adjust_controller_tb;
    import mgac_pkg::*;

    // no transaction on either side for this long means the block is stuck;
    // the longest legal quiet stretch comes from the receiver hold-off
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DIR_ROWS     = 28;
    localparam logic [OCC_W-1:0] OCC_ONE = 11'd1024;

    typedef struct packed {
        logic [GREEN_W-1:0] green;
        logic               regular;
        logic               overwrite;
    } t_green_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] val;
        logic             act;
        logic [OCC_W-1:0] left;
        logic [OCC_W-1:0] right;
        logic             typed;
        t_green_res       res;
    } t_dir_row;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [0] activated, [11:1] left_occ, [22:12] right_occ, [23] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] max_green, [8] in_regular_release, [9] in_overwrite_release, [15:10] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    max_green_adjust_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // register copies
    logic [GREEN_W-1:0] mg_upper   = RST_GREEN_UPPER;
    logic [GREEN_W-1:0] mg_lower   = RST_GREEN_LOWER;
    logic [GREEN_W-1:0] mg_step    = RST_GREEN_STEP;
    logic [OCC_W-1:0]   left_thr   = RST_LEFT_THRESH;
    logic [OCC_W-1:0]   right_thr  = RST_RIGHT_THRESH;
    logic [CNT_W-1:0]   cyc_to_rel = RST_CYC_TO_REL;
    logic [CNT_W-1:0]   reg_cyc    = RST_REGULAR_CYC;
    logic [CNT_W-1:0]   ow_cyc     = RST_OVERWRITE_CYC;

    // controller state copies
    logic [GREEN_W-1:0] last_green    = RST_GREEN_UPPER;
    logic               regular_on    = 1'b0;
    logic               overwrite_on  = 1'b0;
    logic [CNT_W-1:0]   regular_rem   = '0;
    logic [CNT_W-1:0]   overwrite_rem = '0;
    logic [CNT_W-1:0]   adjust_cnt    = '0;
    logic [EXC_W-1:0]   exceed_cnt    = '0;

    t_green_res green_q[$];
    int         mismatches   = 0;
    int         results_seen = 0;
    int         burst_left   = 0;
    bit         no_gaps      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void count_exceedance(input logic [OCC_W-1:0] right);
        if (right > right_thr && exceed_cnt != EXCEED_MAX)
            exceed_cnt++;
    endfunction

    function automatic t_green_res step_green(input logic act, input logic [OCC_W-1:0] left,
                                              input logic [OCC_W-1:0] right);
        t_green_res         r;
        logic [GREEN_W:0]   sum;
        logic [GREEN_W-1:0] g;
        if (!act) begin
            g             = mg_upper;
            last_green    = g;
            regular_on    = 1'b0;
            overwrite_on  = 1'b0;
            regular_rem   = '0;
            overwrite_rem = '0;
            adjust_cnt    = '0;
        end else if (overwrite_on) begin
            g = mg_upper;
            if (overwrite_rem <= 1) begin
                overwrite_rem = '0;
                overwrite_on  = 1'b0;
            end else begin
                overwrite_rem--;
            end
        end else if (regular_on) begin
            g = mg_upper;
            count_exceedance(right);
            if (regular_rem <= 1) begin
                regular_rem = '0;
                regular_on  = 1'b0;
                adjust_cnt  = '0;
                if (exceed_cnt >= EXCEED_TO_OVERWRITE) begin
                    overwrite_on  = 1'b1;
                    overwrite_rem = ow_cyc;
                end
                exceed_cnt = '0;
            end else begin
                regular_rem--;
            end
        end else begin
            if (left > left_thr) begin
                // stepping below zero lands on the lower bound
                if (last_green < mg_step) begin
                    g = mg_lower;
                end else begin
                    g = last_green - mg_step;
                    if (g < mg_lower)
                        g = mg_lower;
                end
            end else begin
                sum = {1'b0, last_green} + {1'b0, mg_step};
                g   = (sum > {1'b0, mg_upper}) ? mg_upper : sum[GREEN_W-1:0];
            end
            count_exceedance(right);
            if (adjust_cnt != ADJUST_MAX)
                adjust_cnt++;
            if (adjust_cnt == cyc_to_rel) begin
                regular_on  = 1'b1;
                regular_rem = reg_cyc;
            end
            last_green = g;
        end
        r.green     = g;
        r.regular   = regular_on;
        r.overwrite = overwrite_on;
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic act, input logic [OCC_W-1:0] left,
                                          input logic [OCC_W-1:0] right);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.act   = act;
        r.left  = left;
        r.right = right;
        return r;
    endfunction

    function automatic t_dir_row chk_row(input logic act, input logic [OCC_W-1:0] left,
                                         input logic [OCC_W-1:0] right,
                                         input logic [GREEN_W-1:0] green,
                                         input logic reg_m, input logic ow_m);
        t_dir_row r;
        r       = item_row(act, left, right);
        r.typed = 1'b1;
        r.res   = '{green, reg_m, ow_m};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // occupancies cluster on the threshold edge and the ends of the range
    function automatic logic [OCC_W-1:0] pick_occ(input logic [OCC_W-1:0] thr);
        logic [OCC_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = OCC_ONE;
            2:       v = thr;
            3:       v = (thr >= OCC_ONE) ? OCC_ONE : thr + 1'b1;
            default: v = OCC_W'($urandom_range(0, 1024));
        endcase
        return v;
    endfunction

    // 8-bit registers may carry junk in the upper write bits
    function automatic logic [CFG_W-1:0] wide8(input int v, input bit junk);
        logic [2:0] hi;
        hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
        return {hi, 8'(v)};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            CFG_GREEN_UPPER:   mg_upper   = val[GREEN_W-1:0];
            CFG_GREEN_LOWER:   mg_lower   = val[GREEN_W-1:0];
            CFG_GREEN_STEP:    mg_step    = val[GREEN_W-1:0];
            CFG_LEFT_THRESH:   left_thr   = val;
            CFG_RIGHT_THRESH:  right_thr  = val;
            CFG_CYC_TO_REL:    cyc_to_rel = val[CNT_W-1:0];
            CFG_REGULAR_CYC:   reg_cyc    = val[CNT_W-1:0];
            CFG_OVERWRITE_CYC: ow_cyc     = val[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_cfg(input int up, input int lo, input int st, input int lt,
                             input int rt, input int ctr, input int rc, input int oc,
                             input bit junk);
        write_reg(CFG_GREEN_UPPER,   wide8(up, junk));
        write_reg(CFG_GREEN_LOWER,   wide8(lo, junk));
        write_reg(CFG_GREEN_STEP,    wide8(st, junk));
        write_reg(CFG_LEFT_THRESH,   CFG_W'(lt));
        write_reg(CFG_RIGHT_THRESH,  CFG_W'(rt));
        write_reg(CFG_CYC_TO_REL,    wide8(ctr, junk));
        write_reg(CFG_REGULAR_CYC,   wide8(rc, junk));
        write_reg(CFG_OVERWRITE_CYC, wide8(oc, junk));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (green_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_item(input logic act, input logic [OCC_W-1:0] left,
                             input logic [OCC_W-1:0] right, input logic typed,
                             input t_green_res typed_res);
        int         gap;
        t_green_res r;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps)
                gap = $urandom_range(0, 6);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, right, left, act};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = step_green(act, left, right);
        green_q.push_back(typed ? typed_res : r);
        burst_left--;
    endtask

    // stimulus
    initial begin
        t_dir_row dir_tbl [DIR_ROWS];
        int       items;
        int       act_pct;
        logic     act;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_GREEN_UPPER;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        dir_tbl = '{
            chk_row(1'b0, 11'd0,    11'd0,    8'd60, 1'b0, 1'b0),
            chk_row(1'b1, OCC_ONE,  OCC_ONE,  8'd55, 1'b0, 1'b0),
            item_row(1'b1, 11'd308, 11'd0),
            item_row(1'b1, 11'd307, 11'd307),
            item_row(1'b1, 11'd0,   11'd308),
            item_row(1'b1, 11'd0,   11'd0),
            item_row(1'b1, OCC_ONE, 11'd0),
            item_row(1'b1, OCC_ONE, 11'd0),
            item_row(1'b1, OCC_ONE, 11'd0),
            item_row(1'b1, OCC_ONE, 11'd0),
            // tenth adjusting cycle starts the regular release
            item_row(1'b1, OCC_ONE, 11'd0),
            item_row(1'b1, 11'd0,   OCC_ONE),
            // enough exceedances: chains into overwrite
            item_row(1'b1, 11'd0,   11'd0),
            item_row(1'b1, 11'd0,   11'd0),
            item_row(1'b1, 11'd0,   11'd0),
            // resumes stepping from the held value
            item_row(1'b1, OCC_ONE, 11'd0),
            chk_row(1'b0, 11'd0,    11'd0,    8'd60, 1'b0, 1'b0),
            cfg_row(CFG_GREEN_STEP,  11'd255),
            cfg_row(CFG_GREEN_LOWER, 11'd100),
            // step below zero and lower bound above upper bound
            chk_row(1'b1, OCC_ONE,  11'd0,    8'd100, 1'b0, 1'b0),
            chk_row(1'b1, 11'd0,    11'd0,    8'd60,  1'b0, 1'b0),
            item_row(1'b0, 11'd0,   11'd0),
            cfg_row(CFG_CYC_TO_REL,    11'd1),
            cfg_row(CFG_REGULAR_CYC,   11'd0),
            cfg_row(CFG_OVERWRITE_CYC, 11'd0),
            // release counters loaded with zero end on the next step
            item_row(1'b1, 11'd0,   OCC_ONE),
            item_row(1'b1, 11'd512, OCC_ONE),
            chk_row(1'b1, 11'd0,    11'd0,    8'd60, 1'b0, 1'b0)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_tbl[i].idx, dir_tbl[i].val);
            end else begin
                send_item(dir_tbl[i].act, dir_tbl[i].left, dir_tbl[i].right,
                          dir_tbl[i].typed, dir_tbl[i].res);
            end
        end

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            items   = 60;
            no_gaps = 1'b0;
            case (p)
                0: begin
                    apply_cfg($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 40), $urandom_range(0, 1024),
                              $urandom_range(0, 1024), $urandom_range(1, 20),
                              $urandom_range(1, 6), $urandom_range(1, 6), 1'b1);
                    act_pct = 90;
                end
                1: begin
                    apply_cfg(0, 0, 0, 0, 0, 1, 1, 1, 1'b0);
                    act_pct = 85;
                end
                2: begin
                    // no release ever starts: the adjust counter saturates and the
                    // exceed count builds up
                    apply_cfg(200, 40, 7, 600, 0, 0, 5, 5, 1'b0);
                    act_pct = 100;
                    items   = 600;
                end
                3: begin
                    // longest release chain; the carried exceed count saturates in the
                    // regular release
                    apply_cfg(255, 255, 255, 1024, 0, 255, 255, 255, 1'b0);
                    act_pct = 100;
                    items   = 780;
                end
                4: begin
                    apply_cfg(30, 90, 20, $urandom_range(0, 1024), 1024,
                              $urandom_range(1, 8), $urandom_range(1, 4),
                              $urandom_range(1, 4), 1'b0);
                    act_pct = 92;
                end
                5: begin
                    apply_cfg($urandom_range(20, 255), $urandom_range(0, 20),
                              $urandom_range(1, 30), $urandom_range(0, 1024),
                              $urandom_range(0, 1024), $urandom_range(1, 12),
                              $urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
                    act_pct = 88;
                    no_gaps = 1'b1;
                end
                default: begin
                    apply_cfg($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 40), $urandom_range(0, 1024),
                              $urandom_range(0, 1024), $urandom_range(1, 20),
                              $urandom_range(1, 6), $urandom_range(1, 6), 1'b1);
                    act_pct = 75;
                end
            endcase
            for (int n = 0; n < items; n++) begin
                act = ($urandom_range(0, 99) < act_pct);
                send_item(act, pick_occ(left_thr), pick_occ(right_thr), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (3) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        bit       held_early;
        bit       held_late;
        mode          = RX_FREE;
        mode_left     = 0;
        tick          = 0;
        held_early    = 1'b0;
        held_late     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if ((!held_early && results_seen >= 200) || (!held_late && results_seen >= 1000)) begin
                if (!held_early)
                    held_early = 1'b1;
                else
                    held_late = 1'b1;
                // long hold-off while the sender keeps offering: the block fills up
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    RX_FREE:     m_axis_tready = 1'b1;
                    RX_COIN:     m_axis_tready = 1'($urandom_range(0, 1));
                    RX_SLOW:     m_axis_tready = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_axis_tready = ((tick % 4) != 0);
                    default:     m_axis_tready = 1'b1;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_green_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (green_q.size() == 0) begin
                report_mismatch("unexpected result transaction", m_axis_tdata, -1);
            end else begin
                want = green_q.pop_front();
                if (m_axis_tdata[7:0] != want.green)
                    report_mismatch("max_green", m_axis_tdata[7:0], want.green);
                if (m_axis_tdata[8] != want.regular)
                    report_mismatch("in_regular_release", m_axis_tdata[8], want.regular);
                if (m_axis_tdata[9] != want.overwrite)
                    report_mismatch("in_overwrite_release", m_axis_tdata[9], want.overwrite);
            end
        end
    end

    // stall watchdog
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
